// ----- design/grco_pkg.sv -----
// Package for the grid ray caster: grid geometry, codes and bus widths.
`default_nettype none
package grco_pkg;

	localparam int GRID_WIDTH  = 256;
	localparam int GRID_HEIGHT = 256;
	localparam int GRID_MAX    = (GRID_WIDTH > GRID_HEIGHT) ? GRID_WIDTH : GRID_HEIGHT;
	localparam int MAP_DEPTH   = GRID_WIDTH * GRID_HEIGHT;
	localparam int ADDR_W      = $clog2(MAP_DEPTH);
	localparam int XW          = $clog2(GRID_WIDTH);
	localparam int YW          = $clog2(GRID_HEIGHT);
	localparam int OFF_W       = $clog2(GRID_MAX) + 1;

	localparam int CELL_W      = 8;
	localparam int COORD_W     = 16;
	localparam int IN_DATA_W   = 72;
	localparam int IN_USER_W   = 1;
	localparam int OUT_DATA_W  = 40;
	localparam int OUT_USER_W  = 2;
	localparam int OX_W        = 9;
	localparam int D2_W        = 17;

	localparam int OFFSET_LIMIT = 255;
	localparam int DIST_LIMIT   = 130050;

	localparam logic [CELL_W-1:0] CELL_FREE     = 8'd0;
	localparam logic [CELL_W-1:0] CELL_OCCUPIED = 8'd100;

	typedef enum logic [0:0] {
		OP_WRITE = 1'b0,
		OP_CAST  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STATUS_NONE = 2'd0,
		STATUS_FREE = 2'd1,
		STATUS_HIT  = 2'd2
	} status_t;

endpackage
`default_nettype wire

// ----- design/grco_ram.sv -----
// Generic single-port RAM with registered read.
`default_nettype none
module grco_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule
`default_nettype wire

// ----- design/grid_ray_cast_obstacle_distance_top.sv -----
// Occupancy grid ray caster: map store, Bresenham walk and distance sequencer.
// Write transaction: accepted, then stored in the following cycle when the cell lies in the grid.
// Cast transaction: INIT sets up the walk; per cell, CHECK issues a registered map read and TEST
// tests it, until an occupied cell, the end point or the grid edge ends the walk, with at most the
// grid side in cells tested; SQX, SQY square the offsets. Next acceptance in the cycle of the result.
// One transaction at a time; a finished result waits in the output register.
// arst_n clears the sequencer and output valid; the map is undefined until written.
`default_nettype none
module grid_ray_cast_obstacle_distance_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// start_x[15:0], start_y[31:16], end_x[47:32], end_y[63:48], cell_value[71:64]
	input  wire logic [grco_pkg::IN_DATA_W-1:0]   s_tdata,
	// op[0]
	input  wire logic [grco_pkg::IN_USER_W-1:0]   s_tuser,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// offset_x[8:0], offset_y[17:9], dist_squared[34:18], zero[39:35]
	output logic      [grco_pkg::OUT_DATA_W-1:0]  m_tdata,
	// status[1:0]
	output logic      [grco_pkg::OUT_USER_W-1:0]  m_tuser
);
	import grco_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_WRITE = 8'b0000_0010,
		ST_INIT  = 8'b0000_0100,
		ST_CHECK = 8'b0000_1000,
		ST_TEST  = 8'b0001_0000,
		ST_SQX   = 8'b0010_0000,
		ST_SQY   = 8'b0100_0000,
		ST_OUT   = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic                      op_q;
	logic signed [COORD_W-1:0] sx_q, sy_q, ex_q, ey_q, cx_q, cy_q;
	logic [CELL_W-1:0]         cell_q;
	logic [COORD_W-1:0]        dx_q, dy_q;
	logic                      stx_q, sty_q;
	logic signed [18:0]        err_q;
	status_t                   status_q;
	logic signed [OFF_W-1:0]   rx_q, ry_q;
	logic [2*OFF_W-1:0]        acc_q, prod_q;

	logic                      m_tvalid_q;
	logic [OUT_DATA_W-1:0]     m_tdata_q;
	logic [OUT_USER_W-1:0]     m_tuser_q;

	// map access
	logic                      in_grid, at_end;
	logic [ADDR_W-1:0]         ram_addr;
	logic                      ram_we;
	logic [CELL_W-1:0]         ram_rdata;

	assign in_grid = (cx_q >= 0) && (int'(cx_q) < GRID_WIDTH) &&
	                 (cy_q >= 0) && (int'(cy_q) < GRID_HEIGHT);
	assign at_end  = (cx_q == ex_q) && (cy_q == ey_q);
	assign ram_addr = ADDR_W'(int'(cy_q[YW-1:0]) * GRID_WIDTH + int'(cx_q[XW-1:0]));
	assign ram_we   = (state_q == ST_WRITE) && in_grid;

	grco_ram #(
		.WIDTH(CELL_W),
		.DEPTH(MAP_DEPTH)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(cell_q),
		.rdata(ram_rdata)
	);

	// Bresenham step
	logic signed [16:0] ddx, ddy;
	logic signed [19:0] e2, dxs, dys;
	logic               step_x, step_y;
	logic signed [19:0] err_nx;

	assign ddx    = 17'(ex_q) - 17'(sx_q);
	assign ddy    = 17'(ey_q) - 17'(sy_q);
	assign e2     = {err_q, 1'b0};
	assign dxs    = $signed({4'b0, dx_q});
	assign dys    = $signed({4'b0, dy_q});
	assign step_x = e2 > -dys;
	assign step_y = e2 < dxs;
	assign err_nx = 20'(err_q) - (step_x ? dys : 20'sd0) + (step_y ? dxs : 20'sd0);

	// shared squaring unit
	logic signed [OFF_W-1:0]   mul_a;
	logic signed [2*OFF_W-1:0] mul_w;
	logic [2*OFF_W-1:0]        mul_p;
	logic [2*OFF_W:0]          sum;
	logic [D2_W-1:0]           d2;
	logic [OX_W-1:0]           ox, oy;

	assign mul_a = (state_q == ST_SQX) ? rx_q : ry_q;
	assign mul_w = (2*OFF_W)'(mul_a);
	assign mul_p = $unsigned(mul_w * mul_w);
	assign sum   = {1'b0, acc_q} + {1'b0, prod_q};

	always_comb begin
		int rxi;
		int ryi;
		rxi = int'(rx_q);
		ryi = int'(ry_q);
		if (rxi > OFFSET_LIMIT) rxi = OFFSET_LIMIT;
		if (rxi < -OFFSET_LIMIT) rxi = -OFFSET_LIMIT;
		if (ryi > OFFSET_LIMIT) ryi = OFFSET_LIMIT;
		if (ryi < -OFFSET_LIMIT) ryi = -OFFSET_LIMIT;
		ox = OX_W'(rxi);
		oy = OX_W'(ryi);
		if (32'(sum) > DIST_LIMIT) begin
			d2 = D2_W'(DIST_LIMIT);
		end else begin
			d2 = D2_W'(sum);
		end
	end

	logic out_free;
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= (op_t'(s_tuser[0]) == OP_CAST) ? ST_INIT : ST_WRITE;
					end
				end
				ST_WRITE: begin
					state_q <= ST_IDLE;
				end
				ST_INIT: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					state_q <= (at_end || !in_grid) ? ST_SQX : ST_TEST;
				end
				ST_TEST: begin
					state_q <= (ram_rdata == CELL_OCCUPIED) ? ST_SQX : ST_CHECK;
				end
				ST_SQX: begin
					state_q <= ST_SQY;
				end
				ST_SQY: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					op_q   <= s_tuser[0];
					sx_q   <= s_tdata[15:0];
					sy_q   <= s_tdata[31:16];
					ex_q   <= s_tdata[47:32];
					ey_q   <= s_tdata[63:48];
					cx_q   <= s_tdata[15:0];
					cy_q   <= s_tdata[31:16];
					cell_q <= s_tdata[71:64];
				end
			end
			ST_INIT: begin
				dx_q     <= COORD_W'(ddx < 0 ? -ddx : ddx);
				dy_q     <= COORD_W'(ddy < 0 ? -ddy : ddy);
				stx_q    <= sx_q < ex_q;
				sty_q    <= sy_q < ey_q;
				err_q    <= 19'(ddx < 0 ? -ddx : ddx) - 19'(ddy < 0 ? -ddy : ddy);
				status_q <= STATUS_NONE;
				rx_q     <= '0;
				ry_q     <= '0;
			end
			ST_TEST: begin
				if (ram_rdata == CELL_FREE) begin
					status_q <= STATUS_FREE;
					rx_q     <= OFF_W'(cx_q - sx_q);
					ry_q     <= OFF_W'(cy_q - sy_q);
				end
				if (ram_rdata == CELL_OCCUPIED) begin
					status_q <= STATUS_HIT;
					rx_q     <= OFF_W'(cx_q - sx_q);
					ry_q     <= OFF_W'(cy_q - sy_q);
				end else begin
					err_q <= 19'(err_nx);
					if (step_x) cx_q <= stx_q ? cx_q + 16'sd1 : cx_q - 16'sd1;
					if (step_y) cy_q <= sty_q ? cy_q + 16'sd1 : cy_q - 16'sd1;
				end
			end
			ST_SQX: begin
				prod_q <= mul_p;
			end
			ST_SQY: begin
				acc_q  <= prod_q;
				prod_q <= mul_p;
			end
			ST_OUT: begin
				if (out_free) begin
					m_tdata_q <= {5'b0, d2, oy, ox};
					m_tuser_q <= status_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	a_load_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_OUT))
		else $error("result raised outside output state");

	a_test_after_check: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TEST) |-> $past(state_q == ST_CHECK))
		else $error("cell test without map read");

	a_square_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> $past(state_q == ST_SQY) || $past(state_q == ST_OUT))
		else $error("output state entered without squaring");

	a_write_no_cast: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> op_t'(op_q) == OP_WRITE)
		else $error("map written during a cast");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && status_q == STATUS_NONE) |-> rx_q == 0 && ry_q == 0)
		else $error("full range result with non-zero offset");

endmodule
`default_nettype wire
